### hw/rtl/ddo_pkg.sv
// shared types, constants and tables for the differential drive odometry block
package ddo_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int SPEED_W    = 16;
    localparam int POS_W      = 32;
    localparam int ANG_W      = 16;
    localparam int TRIG_W     = 32;
    localparam int Z_W        = 34;
    localparam int ATAN_W     = 30;
    localparam int ATAN_IDX_W = 5;
    localparam int DIV_N_W    = 32;
    localparam int DIV_D_W    = 16;
    localparam int DIV_CNT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_TICK  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WBASE = 4'd1;

    localparam logic [CFG_DATA_W-1:0] TICK_RESET  = 16'd6554;
    localparam logic [CFG_DATA_W-1:0] WBASE_RESET = 16'd3473;

    localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [TRIG_W-1:0] INV_PI_Q32   = 32'sd1367130551;

    typedef struct packed {
        logic load;
        logic step;
    } unit_ctrl_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] i);
        logic [ATAN_W-1:0] r;
        case (i)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10680094;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/ddo_cordic.sv
// iterative rotation-mode cordic giving cosine and sine of the heading in q30
module ddo_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ddo_pkg::unit_ctrl_t                 ctrl,
    input  logic [ddo_pkg::ANG_W-1:0]           angle,
    output logic signed [ddo_pkg::TRIG_W-1:0]   cos_q30,
    output logic signed [ddo_pkg::TRIG_W-1:0]   sin_q30,
    output logic                                done
);

    localparam int IDX_W = $clog2(STEPS + 1);

    logic signed [ddo_pkg::TRIG_W-1:0] x_reg, x_next;
    logic signed [ddo_pkg::TRIG_W-1:0] y_reg, y_next;
    logic signed [ddo_pkg::Z_W-1:0]    z_reg, z_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;

    logic                              fold;
    logic [ddo_pkg::ANG_W-1:0]         angle_fold;
    logic signed [ddo_pkg::TRIG_W-1:0] x_sh;
    logic signed [ddo_pkg::TRIG_W-1:0] y_sh;
    logic signed [ddo_pkg::Z_W-1:0]    atan_z;

    assign done = (idx_reg == IDX_W'(STEPS));

    // second and third quadrants rotate by a half turn
    assign fold       = angle[ddo_pkg::ANG_W-1] ^ angle[ddo_pkg::ANG_W-2];
    assign angle_fold = {angle[ddo_pkg::ANG_W-1] ^ fold, angle[ddo_pkg::ANG_W-2:0]};

    assign x_sh   = x_reg >>> idx_reg;
    assign y_sh   = y_reg >>> idx_reg;
    assign atan_z = $signed({4'b0000,
                             ddo_pkg::atan_turn(ddo_pkg::ATAN_IDX_W'(idx_reg))});

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        idx_next = idx_reg;
        if (ctrl.load)
        begin
            x_next   = ddo_pkg::INV_GAIN_Q30;
            y_next   = '0;
            z_next   = $signed({{2{angle_fold[ddo_pkg::ANG_W-1]}}, angle_fold, 16'h0000});
            idx_next = '0;
        end
        else if (ctrl.step && !done)
        begin
            if (!z_reg[ddo_pkg::Z_W-1])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_z;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_z;
            end
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IDX_W'(STEPS);
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign cos_q30 = x_reg;
    assign sin_q30 = y_reg;

endmodule

### hw/rtl/ddo_div.sv
// bit-serial restoring divider for the heading change
module ddo_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ddo_pkg::unit_ctrl_t           ctrl,
    input  logic [ddo_pkg::DIV_N_W-1:0]   numer,
    input  logic [ddo_pkg::DIV_D_W-1:0]   denom,
    output logic [ddo_pkg::ANG_W-1:0]     quotient,
    output logic                          done
);

    logic [ddo_pkg::DIV_N_W-1:0]   num_reg, num_next;
    logic [ddo_pkg::DIV_D_W-1:0]   den_reg, den_next;
    logic [ddo_pkg::DIV_D_W-1:0]   rem_reg, rem_next;
    logic [ddo_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [ddo_pkg::DIV_D_W:0]     rem_sh;
    logic [ddo_pkg::DIV_D_W:0]     rem_sub;
    logic                          fits;

    assign done = (cnt_reg == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_N_W));

    assign rem_sh  = {rem_reg, num_reg[ddo_pkg::DIV_N_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            num_next = numer;
            den_next = denom;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (ctrl.step && !done)
        begin
            // quotient bits shift in where numerator bits leave
            num_next = {num_reg[ddo_pkg::DIV_N_W-2:0], fits};
            rem_next = fits ? rem_sub[ddo_pkg::DIV_D_W-1:0] : rem_sh[ddo_pkg::DIV_D_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_N_W);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quotient = num_reg[ddo_pkg::ANG_W-1:0];

endmodule

### hw/rtl/differential_drive_odometry.sv
// differential drive dead-reckoning pose integrator, top level with sequencer and multiplier
//
//  channel   signals                                   direction
//  in        in_valid/in_ready, left_speed, right_speed  sink
//  out       out_valid/out_ready, pos_x, pos_y, heading  source
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data    sink, always ready
//
// a moving transaction's time from acceptance to result is set by the
// 32-step serial divider, with the cordic running alongside it
// a transaction with both speeds zero skips the arithmetic and goes straight to S_DONE
// one registered 34x32 multiplier serves the heading scale and both displacements
// the result sits in an output register, so the next input is taken while it waits
// reset clears the pose and loads the register defaults
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ddo_pkg::SPEED_W-1:0]  left_speed,
    input  logic signed [ddo_pkg::SPEED_W-1:0]  right_speed,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ddo_pkg::POS_W-1:0]    pos_x,
    output logic signed [ddo_pkg::POS_W-1:0]    pos_y,
    output logic [ddo_pkg::ANG_W-1:0]           heading,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_MAG   = 9'b000000100,
        S_DIVLD = 9'b000001000,
        S_RUN   = 9'b000010000,
        S_MULX  = 9'b000100000,
        S_MULY  = 9'b001000000,
        S_ACCY  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [ddo_pkg::CFG_DATA_W-1:0]      tick_reg;
    logic [ddo_pkg::CFG_DATA_W-1:0]      wbase_reg;

    logic signed [ddo_pkg::SPEED_W-1:0]  vl_reg;
    logic signed [ddo_pkg::SPEED_W-1:0]  vr_reg;
    logic signed [ddo_pkg::POS_W-1:0]    xpos_reg;
    logic signed [ddo_pkg::POS_W-1:0]    ypos_reg;
    logic [ddo_pkg::ANG_W-1:0]           hdg_reg;
    logic signed [33:0]                  d_reg;
    logic [31:0]                         adiff_reg;
    logic                                hneg_reg;
    logic signed [65:0]                  prod_reg;

    logic signed [ddo_pkg::POS_W-1:0]    pos_x_reg;
    logic signed [ddo_pkg::POS_W-1:0]    pos_y_reg;
    logic [ddo_pkg::ANG_W-1:0]           heading_reg;
    logic                                out_valid_reg;

    logic                                accept;
    logic                                out_load;
    logic signed [16:0]                  spd_sum;
    logic signed [16:0]                  spd_diff;
    logic                                fold;
    logic signed [17:0]                  sum_adj;
    logic signed [34:0]                  d_prod;
    logic [16:0]                         diff_mag;
    logic [32:0]                         adiff_prod;
    logic signed [33:0]                  mul_a;
    logic signed [31:0]                  mul_b;
    logic signed [65:0]                  mul_p;
    logic [63:0]                         mag_round;
    logic [ddo_pkg::DIV_D_W-1:0]         den;
    logic signed [65:0]                  prod_round;
    logic signed [27:0]                  delta;

    ddo_pkg::unit_ctrl_t                 cordic_ctrl;
    ddo_pkg::unit_ctrl_t                 div_ctrl;
    logic signed [ddo_pkg::TRIG_W-1:0]   cos_q30;
    logic signed [ddo_pkg::TRIG_W-1:0]   sin_q30;
    logic                                cordic_done;
    logic [ddo_pkg::ANG_W-1:0]           quotient;
    logic                                div_done;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [27:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {{5{b[27]}}, b};
        if (s[32] != s[31])
            return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        return s[31:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = !out_valid_reg || out_ready;

    // travel and turn terms
    assign spd_sum    = {vl_reg[15], vl_reg} + {vr_reg[15], vr_reg};
    assign spd_diff   = {vr_reg[15], vr_reg} - {vl_reg[15], vl_reg};
    assign fold       = hdg_reg[15] ^ hdg_reg[14];
    assign sum_adj    = fold ? -{spd_sum[16], spd_sum} : {spd_sum[16], spd_sum};
    assign d_prod     = sum_adj * $signed({1'b0, tick_reg});
    assign diff_mag   = spd_diff[16] ? 17'(-spd_diff) : spd_diff;
    assign adiff_prod = diff_mag * tick_reg;

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MAG:
            begin
                mul_a = $signed({2'b00, adiff_reg});
                mul_b = ddo_pkg::INV_PI_Q32;
            end
            S_MULX:
            begin
                mul_a = d_reg;
                mul_b = cos_q30;
            end
            S_MULY:
            begin
                mul_a = d_reg;
                mul_b = sin_q30;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign den        = (wbase_reg == '0) ? 16'd1 : wbase_reg;
    assign mag_round  = prod_reg[63:0] + {17'b0, den, 31'b0};
    assign prod_round = prod_reg + (66'sd1 <<< 37);
    assign delta      = prod_round[65:38];

    assign cordic_ctrl.load = (state_reg == S_PREP);
    assign cordic_ctrl.step = (state_reg == S_MAG) || (state_reg == S_DIVLD)
                              || (state_reg == S_RUN);
    assign div_ctrl.load    = (state_reg == S_DIVLD);
    assign div_ctrl.step    = (state_reg == S_RUN);

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cordic_ctrl),
        .angle   (hdg_reg),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30),
        .done    (cordic_done)
    );

    ddo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .numer    (mag_round[63:32]),
        .denom    (den),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (left_speed == '0 && right_speed == '0) ? S_DONE : S_PREP;
            end
            S_PREP:  state_next = S_MAG;
            S_MAG:   state_next = S_DIVLD;
            S_DIVLD: state_next = S_RUN;
            S_RUN:
            begin
                if (div_done && cordic_done)
                    state_next = S_MULX;
            end
            S_MULX:  state_next = S_MULY;
            S_MULY:  state_next = S_ACCY;
            S_ACCY:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= ddo_pkg::TICK_RESET;
            wbase_reg     <= ddo_pkg::WBASE_RESET;
            xpos_reg      <= '0;
            ypos_reg      <= '0;
            hdg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ddo_pkg::REG_TICK:  tick_reg  <= cfg_data;
                    ddo_pkg::REG_WBASE: wbase_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_MULY)
                xpos_reg <= sat_add(xpos_reg, delta);
            if (state_reg == S_ACCY)
            begin
                ypos_reg <= sat_add(ypos_reg, delta);
                hdg_reg  <= hneg_reg ? hdg_reg - quotient : hdg_reg + quotient;
            end
            if (state_reg == S_DONE && out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vl_reg <= left_speed;
            vr_reg <= right_speed;
        end
        if (state_reg == S_PREP)
        begin
            d_reg     <= d_prod[33:0];
            adiff_reg <= adiff_prod[31:0];
            hneg_reg  <= spd_diff[16];
        end
        if (state_reg == S_MAG || state_reg == S_MULX || state_reg == S_MULY)
            prod_reg <= mul_p;
        if (state_reg == S_DONE && out_load)
        begin
            pos_x_reg   <= xpos_reg;
            pos_y_reg   <= ypos_reg;
            heading_reg <= hdg_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer still idle after an accepted transaction");

    a_still_skips: assert property (@(posedge clk) disable iff (!rst_n)
        accept && left_speed == '0 && right_speed == '0 |=> state_reg == S_DONE)
        else $error("zero-speed transaction did not skip the arithmetic");

    a_units_finished: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MULX |-> cordic_done && div_done)
        else $error("displacement started before cordic and divider finished");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !out_valid_reg |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished pose not moved to the output register");
`endif

endmodule
